FILE: hw/rtl/splq_pkg.sv
// Shared types and codes for the sorted priority list unit.
package splq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_UPD
  } fsm_e;

  typedef struct packed {
    logic load;
    logic cmp;
    logic upd;
  } dp_cmd_t;

endpackage

FILE: hw/rtl/splq_in_if.sv
// Request channel: operation and value with a valid/ready handshake.
interface splq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

FILE: hw/rtl/splq_out_if.sv
// Result channel: one result item per request with a valid/ready handshake.
interface splq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] popped_value;
  logic        found;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  logic        is_empty;

  modport source (output valid, output popped_value, output found, output status,
                  output entry_count, output is_empty, input ready);
  modport sink (input valid, input popped_value, input found, input status,
                input entry_count, input is_empty, output ready);
endinterface

FILE: hw/rtl/splq_ctrl.sv
// Controller: sequences capture, compare and update, and owns the result valid.
module splq_ctrl
  import splq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: if (in_valid_i) state_d = FSM_CMP;
      FSM_CMP:  state_d = FSM_UPD;
      FSM_UPD:  if (slot_free) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      FSM_CMP:  cmd_o.cmp = 1'b1;
      FSM_UPD:  cmd_o.upd = slot_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.upd) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/splq_dpath.sv
// Datapath: a row of sorted cells, each with its own comparator, plus the result register.
module splq_dpath
  import splq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [1:0]  operation_i,
  input  logic [31:0] value_i,
  output logic [31:0] popped_value_o,
  output logic        found_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o,
  output logic        is_empty_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] entry_q [DEPTH];
  logic [DATA_WIDTH-1:0] entry_d [DEPTH];
  logic [DEPTH-1:0]      occ_q, occ_d;
  logic [DEPTH-1:0]      le_q, eq_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [1:0]            op_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [DATA_WIDTH+31:0] val_ext;
  logic [DATA_WIDTH+31:0] pop_ext;
  logic [CW+4:0]          cnt_ext;

  logic [DEPTH-1:0] keep;      // occupied and not above the operand
  logic [DEPTH-1:0] take_v;
  logic [DEPTH-1:0] take_prev;
  logic [DEPTH-1:0] shift_up;
  logic             full, empty, hit;
  logic             do_ins, do_del, do_pop;
  status_e          status_d;

  assign val_ext = {{DATA_WIDTH{1'b0}}, value_i};
  assign full    = occ_q[DEPTH-1];
  assign empty   = !occ_q[0];
  assign hit     = |(eq_q & occ_q);
  assign keep    = occ_q & le_q;

  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_pop   = 1'b0;
    status_d = ST_DONE;
    unique case (op_e'(op_q))
      OP_INSERT: begin
        if (full) status_d = ST_FULL;
        else      do_ins   = 1'b1;
      end
      OP_POP: begin
        if (empty) status_d = ST_EMPTY;
        else       do_pop   = 1'b1;
      end
      OP_FIND: begin
        if (!hit) status_d = ST_ABSENT;
      end
      OP_REMOVE: begin
        if (!hit) status_d = ST_ABSENT;
        else      do_del   = 1'b1;
      end
      default: status_d = ST_DONE;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign take_v[i]    = !keep[i];
      assign take_prev[i] = 1'b0;
    end else begin : g_body
      assign take_v[i]    = !keep[i] && keep[i-1];
      assign take_prev[i] = !keep[i-1];
    end
    // On a delete every cell from the first equal entry onwards moves down by one.
    assign shift_up[i] = do_pop || (do_del && occ_q[i] && !(le_q[i] && !eq_q[i]));

    always_comb begin
      entry_d[i] = entry_q[i];
      if (do_ins) begin
        if (take_v[i]) begin
          entry_d[i] = val_q;
        end else if (take_prev[i]) begin
          entry_d[i] = entry_q[(i > 0) ? i - 1 : 0];
        end
      end else if (shift_up[i] && i < DEPTH - 1) begin
        entry_d[i] = entry_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.upd) begin
        entry_q[i] <= entry_d[i];
      end
      if (cmd_i.cmp) begin
        le_q[i] <= entry_q[i] <= val_q;
        eq_q[i] <= entry_q[i] == val_q;
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    cnt_d = cnt_q;
    if (do_ins) begin
      occ_d = {occ_q[DEPTH-2:0], 1'b1};
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop || do_del) begin
      occ_d = occ_q >> 1;
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.upd) begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      val_q <= val_ext[DATA_WIDTH-1:0];
    end
  end

  assign pop_ext = {32'b0, entry_q[0]};
  assign cnt_ext = {5'b0, cnt_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      popped_value_o <= do_pop ? pop_ext[31:0] : 32'b0;
      found_o        <= hit && (op_e'(op_q) == OP_FIND || op_e'(op_q) == OP_REMOVE);
      status_o       <= status_d;
      entry_count_o  <= cnt_ext[4:0];
      is_empty_o     <= (cnt_d == '0);
    end
  end

endmodule

FILE: hw/rtl/sorted_priority_list_unit.sv
// Top level of the sorted priority list unit: controller, cell datapath and channels.
//
// A request item on in_i carries an operation (insert, pop smallest, find,
// remove first equal) and a value. Exactly one result item per request leaves
// on out_o with the popped value, a found flag, a status code, the entry count
// after the operation and an empty flag.
// Each request runs as capture, a compare in every cell at once, then the
// update of the cells and the result register. The next request can be taken
// in the cycle after the update; no request is accepted while the previous
// one is still in compare or update. The result register lets a new request
// enter while the previous result still waits; if the receiver stalls, the
// update of the following request waits until the result register frees.
// Reset empties the store at once (occupancy bits and count clear); the stored
// values themselves are not cleared and are never read before being written.
// Insert into a full store is dropped with status full; pop on an empty store
// reports status empty; find or remove of a missing value reports absent.
module sorted_priority_list_unit
  import splq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  splq_in_if.sink    in_i,
  splq_out_if.source out_o
);

  dp_cmd_t cmd;

  splq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  splq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (in_i.operation),
    .value_i        (in_i.value),
    .popped_value_o (out_o.popped_value),
    .found_o        (out_o.found),
    .status_o       (out_o.status),
    .entry_count_o  (out_o.entry_count),
    .is_empty_o     (out_o.is_empty)
  );

  // Only one step of the sequence is commanded in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("more than one datapath command at once");

  // An accepted item is compared in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> cmd.cmp)
    else $error("accepted item was not compared");

  // An update always presents a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.upd |=> out_o.valid)
    else $error("update did not produce a result");

  // An empty store reports a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_empty |-> out_o.entry_count == 5'd0)
    else $error("empty flag with non-zero count");

endmodule

FILE: test/tb.sv
// Testbench for the sorted priority list unit: directed and random requests against a shadow store.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import splq_pkg::*;

  localparam int          DEPTH        = 16;
  localparam int          DATA_WIDTH   = 32;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned ITEMS_PHASE  = 100;

  typedef struct packed {
    logic [31:0] popped_value;
    logic        found;
    status_e     status;
    logic [4:0]  entry_count;
    logic        is_empty;
  } result_t;

  // Shadow copy of the sorted store plus the results it predicts, oldest first.
  class sorted_list_tracker;
    logic [31:0]  shadow [DEPTH];
    int unsigned  fill = 0;
    result_t      due_results [$];
    int unsigned  mismatches = 0;

    function void drop_slot(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < fill; i++) shadow[i] = shadow[i + 1];
      fill--;
    endfunction

    function void note_request(op_e op, logic [31:0] value);
      result_t     r;
      int unsigned pos;
      int unsigned i;
      r = '0;
      r.status = ST_DONE;
      case (op)
        OP_INSERT: begin
          if (fill == DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // Equal values go behind the ones already held, so arrival order is kept.
            pos = 0;
            while (pos < fill && shadow[pos] <= value) pos++;
            for (i = fill; i > pos; i--) shadow[i] = shadow[i - 1];
            shadow[pos] = value;
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped_value = shadow[0];
            drop_slot(0);
          end
        end
        default: begin
          pos = 0;
          while (pos < fill && shadow[pos] != value) pos++;
          if (pos < fill) begin
            r.found = 1'b1;
            if (op == OP_REMOVE) drop_slot(pos);
          end else begin
            r.status = ST_ABSENT;
          end
        end
      endcase
      r.entry_count = 5'(fill);
      r.is_empty    = (fill == 0);
      due_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result item with nothing pending: pop=%h found=%b st=%0d cnt=%0d emp=%b",
                   $realtime, got.popped_value, got.found, got.status, got.entry_count,
                   got.is_empty);
      end else begin
        want = due_results.pop_front();
        if (got.popped_value !== want.popped_value || got.found !== want.found ||
            got.status !== want.status || got.entry_count !== want.entry_count ||
            got.is_empty !== want.is_empty) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected pop=%h found=%b st=%0d cnt=%0d emp=%b, got pop=%h found=%b st=%0d cnt=%0d emp=%b",
                     $realtime, want.popped_value, want.found, want.status,
                     want.entry_count, want.is_empty, got.popped_value, got.found,
                     got.status, got.entry_count, got.is_empty);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  splq_in_if  req_if ();
  splq_out_if rsp_if ();

  sorted_list_tracker tracker = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_on    = 1'b0;

  sorted_priority_list_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one request item after a random gap and returns once it is taken.
  task automatic send_item(input op_e op, input logic [31:0] value);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.note_request(op, value);
  endtask

  // Mostly values already held or small ones, so that finds and removes hit and
  // duplicates pile up; the rest are extremes and fully random words.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40 && tracker.fill != 0) return tracker.shadow[$urandom_range(tracker.fill - 1)];
    if (r < 75) return 32'($urandom_range(15));
    if (r < 85) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Runs through filling, balanced and draining stretches so that both the full
  // and the empty store are reached repeatedly.
  task automatic run_random(input int unsigned n_items);
    int unsigned k;
    int unsigned pick;
    int unsigned w_ins;
    int unsigned w_pop;
    int unsigned w_find;
    op_e         op;
    for (k = 0; k < n_items; k++) begin
      case ((k / 28) % 3)
        0:       begin w_ins = 75; w_pop = 10; w_find = 5;  end
        1:       begin w_ins = 35; w_pop = 25; w_find = 20; end
        default: begin w_ins = 10; w_pop = 50; w_find = 10; end
      endcase
      pick = $urandom_range(99);
      if (pick < w_ins)                       op = OP_INSERT;
      else if (pick < w_ins + w_pop)          op = OP_POP;
      else if (pick < w_ins + w_pop + w_find) op = OP_FIND;
      else                                    op = OP_REMOVE;
      send_item(op, pick_value());
    end
  endtask

  // Result side: checks every accepted result and stalls at random, with one
  // long hold-off when pressure is asked for.
  initial begin
    int unsigned hold_left;
    bit          pressure_seen;
    result_t     got;
    hold_left     = 0;
    pressure_seen = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.popped_value = rsp_if.popped_value;
        got.found        = rsp_if.found;
        got.status       = status_e'(rsp_if.status);
        got.entry_count  = rsp_if.entry_count;
        got.is_empty     = rsp_if.is_empty;
        tracker.check_result(got);
      end
      if (pressure_on && !pressure_seen) hold_left = HOLD_CYCLES;
      pressure_seen = pressure_on;
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Ends the run if no item moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned i;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_INSERT;
    req_if.value     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: everything on an empty store, then fill it with a duplicate at
    // the bottom and an insert past full, then hits, misses and removal at the head.
    send_item(OP_POP,    32'h0000_0000);
    send_item(OP_FIND,   32'h0000_0000);
    send_item(OP_REMOVE, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    for (i = 0; i < 14; i++) send_item(OP_INSERT, 32'((i * 5) % 14));
    send_item(OP_INSERT, 32'h0000_0009);
    send_item(OP_FIND,   32'h0000_0005);
    send_item(OP_FIND,   32'h8000_0000);
    send_item(OP_REMOVE, 32'h0000_0000);
    send_item(OP_REMOVE, 32'h0000_0009);
    send_item(OP_POP,    32'hFFFF_FFFF);
    send_item(OP_POP,    32'h0000_0000);

    run_random(ITEMS_PHASE);

    // Long receiver hold-off while requests keep coming, so the input backs up.
    pressure_on = 1'b1;
    run_random(30);
    pressure_on = 1'b0;

    send_idle_pct  = 68;
    recv_stall_pct = 0;
    run_random(ITEMS_PHASE);

    send_idle_pct  = 0;
    recv_stall_pct = 68;
    run_random(ITEMS_PHASE);

    send_idle_pct  = 32;
    recv_stall_pct = 32;
    run_random(ITEMS_PHASE);

    req_if.valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sorted_priority_list_unit.f
hw/rtl/splq_pkg.sv
hw/rtl/splq_in_if.sv
hw/rtl/splq_out_if.sv
hw/rtl/splq_ctrl.sv
hw/rtl/splq_dpath.sv
hw/rtl/sorted_priority_list_unit.sv
test/tb.sv
